// ----- rtl/sfn_pkg.sv -----
// Shared types and constants for the short file name normalizer.
`default_nettype none

package sfn_pkg;

    localparam int NAME_LEN = 11;
    localparam int BASE_LEN = 8;
    localparam int EXT_LEN  = NAME_LEN - BASE_LEN;

    typedef logic [7:0] byte_t;
    typedef logic [3:0] pos_t;

    localparam byte_t ZERO_BYTE = 8'h00;
    localparam byte_t PAD_BYTE  = 8'h20;
    localparam byte_t DOT_BYTE  = 8'h2e;
    localparam byte_t CASE_GAP  = 8'h20;   // 'a' - 'A'
    localparam byte_t LOWER_A   = 8'h61;
    localparam byte_t LOWER_Z   = 8'h7a;

    localparam pos_t BASE_POS = pos_t'(BASE_LEN);
    localparam pos_t NAME_END = pos_t'(NAME_LEN);

    // Classification of one incoming byte.
    typedef struct packed {
        logic  is_zero;
        logic  is_dot;
        logic  forbidden;
        byte_t upper;
    } char_class_t;

    // One finished name.
    typedef struct packed {
        logic [8*BASE_LEN-1:0] base;
        logic [8*EXT_LEN-1:0]  ext;
        logic                  status;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/short_filename_normalizer.sv -----
// Top level of the FAT 8.3 short file name normalizer.
//
// Input channel (in_valid / in_stall / char_code): one name byte per
// transaction, a zero byte ends the name. Bytes are folded to upper case
// and placed into an 8-byte base and a 3-byte extension, space padded.
// Output channel (out_valid / out_stall / base_part / ext_part / status):
// one transaction per zero byte. status 1 flags an invalid name (empty,
// leading dot, forbidden byte, second dot, over-long base or extension);
// base_part and ext_part are then zero.
// Throughput: one byte per cycle, back to back, while in_stall is low. The
// result of a terminator goes into the result register, or into the skid
// entry while the result register holds a stalled result.
// Stall: a two-entry output (result register plus skid entry) lets the
// input keep taking bytes while a result waits; in_stall rises only when
// both entries hold results, and comes from a flop.
// Reset: asynchronous, active low; clears the name to spaces, the write
// position and the dot/error flags, sets first_reg, empties the output.
`default_nettype none

module short_filename_normalizer (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire  [7:0]  char_code,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [63:0] base_part,
    output logic [23:0] ext_part,
    output logic        status
);
    import sfn_pkg::*;

    char_class_t cls;
    result_t     result;
    result_t     dout;
    logic        accept;
    logic        push;

    assign accept = in_valid && !in_stall;

    sfn_classify u_classify (
        .char_code (char_code),
        .cls       (cls)
    );

    sfn_name u_name (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .cls    (cls),
        .push   (push),
        .result (result)
    );

    sfn_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .din       (result),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .dout      (dout),
        .full      (in_stall)
    );

    assign base_part = dout.base;
    assign ext_part  = dout.ext;
    assign status    = dout.status;

endmodule

`default_nettype wire

// ----- rtl/sfn_classify.sv -----
// Byte classifier: terminator, dot, forbidden set and upper-case fold.
`default_nettype none

module sfn_classify (
    input  wire sfn_pkg::byte_t       char_code,
    output sfn_pkg::char_class_t      cls
);
    import sfn_pkg::*;

    always_comb
    begin
        cls.is_zero   = (char_code == ZERO_BYTE);
        cls.is_dot    = (char_code == DOT_BYTE);
        cls.forbidden = (char_code < 8'h20) || char_code[7]
                      || (char_code == 8'h22) || (char_code == 8'h7c)
                      || ((char_code >= 8'h2a) && (char_code <= 8'h2f))
                      || ((char_code >= 8'h3a) && (char_code <= 8'h3f))
                      || ((char_code >= 8'h5b) && (char_code <= 8'h5d));
        if ((char_code >= LOWER_A) && (char_code <= LOWER_Z))
        begin
            cls.upper = char_code - CASE_GAP;
        end
        else
        begin
            cls.upper = char_code;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sfn_name.sv -----
// Name state: byte store, write position, flags; forms the result on the terminator.
`default_nettype none

module sfn_name (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  accept,
    input  wire sfn_pkg::char_class_t cls,
    output logic                 push,
    output sfn_pkg::result_t     result
);
    import sfn_pkg::*;

    byte_t store_reg [NAME_LEN];
    byte_t store_next [NAME_LEN];
    pos_t  pos_reg, pos_next;
    logic  ext_reg, ext_next;
    logic  err_reg, err_next;
    logic  first_reg, first_next;
    logic  do_store;
    logic  bad;

    always_comb
    begin
        store_next = store_reg;
        pos_next   = pos_reg;
        ext_next   = ext_reg;
        err_next   = err_reg;
        first_next = first_reg;
        do_store   = 1'b0;
        push       = 1'b0;
        if (accept)
        begin
            if (cls.is_zero)
            begin
                push = 1'b1;
                for (int i = 0; i < NAME_LEN; i++)
                begin
                    store_next[i] = PAD_BYTE;
                end
                pos_next   = '0;
                ext_next   = 1'b0;
                err_next   = 1'b0;
                first_next = 1'b1;
            end
            else if (err_reg)
            begin
                first_next = 1'b0;
            end
            else
            begin
                first_next = 1'b0;
                priority if (first_reg && cls.is_dot)
                begin
                    err_next = 1'b1;
                end
                else if (!ext_reg)
                begin
                    priority if (cls.is_dot)
                    begin
                        ext_next = 1'b1;
                        pos_next = BASE_POS;
                    end
                    else if ((pos_reg >= BASE_POS) || cls.forbidden)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        do_store = 1'b1;
                    end
                end
                else
                begin
                    if ((pos_reg >= NAME_END) || cls.forbidden)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        do_store = 1'b1;
                    end
                end
                if (do_store)
                begin
                    if (pos_reg < NAME_END)
                    begin
                        store_next[pos_reg] = cls.upper;
                    end
                    pos_next = pos_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NAME_LEN; i++)
            begin
                store_reg[i] <= PAD_BYTE;
            end
            pos_reg   <= '0;
            ext_reg   <= 1'b0;
            err_reg   <= 1'b0;
            first_reg <= 1'b1;
        end
        else
        begin
            store_reg <= store_next;
            pos_reg   <= pos_next;
            ext_reg   <= ext_next;
            err_reg   <= err_next;
            first_reg <= first_next;
        end
    end

    // Invalid names report zero payload.
    assign bad = err_reg || first_reg;

    always_comb
    begin
        result.base   = '0;
        result.ext    = '0;
        result.status = bad;
        if (!bad)
        begin
            for (int i = 0; i < BASE_LEN; i++)
            begin
                result.base[8*(BASE_LEN-1-i) +: 8] = store_reg[i];
            end
            for (int i = 0; i < EXT_LEN; i++)
            begin
                result.ext[8*(EXT_LEN-1-i) +: 8] = store_reg[BASE_LEN+i];
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sfn_outbuf.sv -----
// Result register with a skid entry so input keeps flowing under output stall.
`default_nettype none

module sfn_outbuf (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               push,
    input  wire sfn_pkg::result_t din,
    input  wire               out_stall,
    output logic              out_valid,
    output sfn_pkg::result_t  dout,
    output logic              full
);
    import sfn_pkg::*;

    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    main_v_reg, main_v_next;
    logic    skid_v_reg, skid_v_next;
    logic    take;

    assign take = main_v_reg && !out_stall;

    always_comb
    begin
        main_next   = main_reg;
        skid_next   = skid_reg;
        main_v_next = main_v_reg;
        skid_v_next = skid_v_reg;
        if (!main_v_reg || take)
        begin
            if (skid_v_reg)
            begin
                main_next   = skid_reg;
                main_v_next = 1'b1;
                skid_v_next = 1'b0;
            end
            else
            begin
                main_next   = din;
                main_v_next = push;
            end
        end
        else if (push)
        begin
            skid_next   = din;
            skid_v_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            main_v_reg <= main_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign out_valid = main_v_reg;
    assign dout      = main_reg;
    assign full      = skid_v_reg;

endmodule

`default_nettype wire

// ----- rtl/sfn_checker.sv -----
// Port-level checks for the short file name normalizer, bound to the top level.
`default_nettype none

module sfn_checker (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    input  wire        in_stall,
    input  wire [7:0]  char_code,
    input  wire        out_valid,
    input  wire        out_stall,
    input  wire [63:0] base_part,
    input  wire [23:0] ext_part,
    input  wire        status
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped under stall");

    // Input back-pressure only with a result waiting.
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("in_stall without pending result");

    // After a terminator is taken, some result is offered on the next cycle.
    a_term_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (char_code == 8'h00) |=> out_valid)
        else $error("no result after terminator");

    // Invalid names carry an all-zero payload.
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> (base_part == 64'h0) && (ext_part == 24'h0))
        else $error("invalid name with nonzero payload");

    // Valid names never start with a dot or hold one in the extension.
    a_no_dot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !status |-> (base_part[63:56] != 8'h2e)
            && (ext_part[23:16] != 8'h2e) && (ext_part[15:8] != 8'h2e)
            && (ext_part[7:0] != 8'h2e))
        else $error("dot inside a valid short name");

endmodule

bind short_filename_normalizer sfn_checker u_sfn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_code (char_code),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .base_part (base_part),
    .ext_part  (ext_part),
    .status    (status)
);

`default_nettype wire
